FILE: src/weightless_net_trainer_assert.svh
// Assertion macros used by the port checker of the trainer.
`ifndef WEIGHTLESS_NET_TRAINER_ASSERT_SVH
`define WEIGHTLESS_NET_TRAINER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WNT_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WNT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wnt_pkg.sv
package wnt_pkg;

    // Default sizes of the network.
    localparam int TOTAL_BITS_DEF  = 64;
    localparam int ADDR_BITS_DEF   = 4;
    localparam int RAM_COUNT_DEF   = 16;
    localparam int CLASS_COUNT_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths of the ports.
    localparam int CMD_W       = 2;
    localparam int PATTERN_W   = 64;
    localparam int CLASS_W     = 3;
    localparam int SLOT_W      = 6;
    localparam int SRC_W       = 6;
    localparam int RSEL_W      = 4;
    localparam int RADDR_W     = 4;
    localparam int COUNT_OUT_W = 16;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] RAMS_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TRAIN = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRAIN,
        ST_READ,
        ST_RDATA,
        ST_DONE
    } st_t;

    // Read and write strobes of one memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic                   push;
        logic                   read_valid;
        logic [COUNT_OUT_W-1:0] count;
    } res_t;

endpackage

FILE: src/wnt_map_ram.sv
module wnt_map_ram
    import wnt_pkg::*;
#(
    parameter int RAM_COUNT = RAM_COUNT_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    localparam int ROW_W  = (RAM_COUNT > 1) ? $clog2(RAM_COUNT) : 1,
    localparam int LANE_W = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1
)
(
    input  logic                              clk,
    input  mem_ctl_t                          ctl,
    input  logic [ROW_W-1:0]                  wr_row,
    input  logic [LANE_W-1:0]                 wr_lane,
    input  logic [SRC_W-1:0]                  wr_data,
    input  logic [ROW_W-1:0]                  rd_row,
    output logic [ADDR_BITS-1:0][SRC_W-1:0]   rd_data
);

    // One row per RAM, one lane per address bit.
    logic [ADDR_BITS-1:0][SRC_W-1:0] mem [RAM_COUNT];

    // Single-lane write of one map entry.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_row][wr_lane] <= wr_data;
        end
    end

    // Registered read of a whole row.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_row];
        end
    end

endmodule

FILE: src/wnt_cnt_ram.sv
module wnt_cnt_ram
    import wnt_pkg::*;
#(
    parameter int DEPTH = CLASS_COUNT_DEF * RAM_COUNT_DEF * (1 << ADDR_BITS_DEF),
    parameter int WIDTH = COUNT_WIDTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  mem_ctl_t         ctl,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

FILE: src/wnt_seq.sv
module wnt_seq
    import wnt_pkg::*;
#(
    parameter int TOTAL_BITS  = TOTAL_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int RAM_COUNT   = RAM_COUNT_DEF,
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int RAM_SIZE  = 1 << ADDR_BITS,
    localparam int MAP_DEPTH = RAM_COUNT * ADDR_BITS,
    localparam int CNT_DEPTH = CLASS_COUNT * RAM_COUNT * RAM_SIZE,
    localparam int CIDX_W    = $clog2(CNT_DEPTH),
    localparam int ROW_W     = (RAM_COUNT > 1) ? $clog2(RAM_COUNT) : 1,
    localparam int LANE_W    = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1,
    localparam int RCNT_W    = $clog2(RAM_COUNT + 1)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [CMD_W-1:0]                  command,
    input  logic [PATTERN_W-1:0]              pattern,
    input  logic [CLASS_W-1:0]                class_index,
    input  logic [SLOT_W-1:0]                 map_slot,
    input  logic [SRC_W-1:0]                  source_bit,
    input  logic [RSEL_W-1:0]                 ram_select,
    input  logic [RADDR_W-1:0]                ram_address,
    input  logic [CFG_W-1:0]                  rams_in_use,
    input  logic                              out_free,
    output res_t                              res,
    output mem_ctl_t                          map_ctl,
    output logic [ROW_W-1:0]                  map_wr_row,
    output logic [LANE_W-1:0]                 map_wr_lane,
    output logic [SRC_W-1:0]                  map_wr_data,
    output logic [ROW_W-1:0]                  map_rd_row,
    input  logic [ADDR_BITS-1:0][SRC_W-1:0]   map_rd_data,
    output mem_ctl_t                          cnt_ctl,
    output logic [CIDX_W-1:0]                 cnt_wr_idx,
    output logic [COUNT_WIDTH-1:0]            cnt_wr_data,
    output logic [CIDX_W-1:0]                 cnt_rd_idx,
    input  logic [COUNT_WIDTH-1:0]            cnt_rd_data
);

    st_t                    state_reg, state_next;
    logic                   clr_cmd_reg, clr_cmd_next;
    logic [CIDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [RCNT_W-1:0]      ram_cnt_reg, ram_cnt_next;
    logic [RCNT_W-1:0]      limit_reg, limit_next;
    logic                   p1_valid_reg, p1_valid_next;
    logic                   p2_valid_reg, p2_valid_next;
    logic [ROW_W-1:0]       p1_ram_reg;
    logic [CIDX_W-1:0]      p2_idx_reg;
    cmd_t                   cmd_reg;
    logic [PATTERN_W-1:0]   pattern_reg;
    logic [CLASS_W-1:0]     cls_reg;
    logic [RSEL_W-1:0]      rsel_reg;
    logic [RADDR_W-1:0]     raddr_reg;
    logic                   rd_ok_reg;
    logic [COUNT_OUT_W-1:0] res_count_reg, res_count_next;

    logic                   accept;
    cmd_t                   in_cmd;
    logic                   cls_ok;
    logic                   slot_ok;
    logic                   rd_ok;
    logic [ROW_W-1:0]       slot_row;
    logic [LANE_W-1:0]      slot_lane;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [CIDX_W-1:0]      train_idx;
    logic [CIDX_W-1:0]      read_idx;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [31:0]            cnt_wide;
    logic                   train_done;

    // Flat counter index of class c, RAM r, address a.
    function automatic logic [CIDX_W-1:0] cnt_index(
        input logic [CLASS_W-1:0]   c,
        input logic [ROW_W-1:0]     r,
        input logic [ADDR_BITS-1:0] a
    );
        logic [CIDX_W-1:0] row;
        row = CIDX_W'(c) * CIDX_W'(RAM_COUNT) + CIDX_W'(r);
        return CIDX_W'(row << ADDR_BITS) + CIDX_W'(a);
    endfunction

    // Input handshake: one transaction at a time.
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_cmd   = cmd_t'(command);

    // Range checks on the incoming fields.
    assign cls_ok  = 32'(class_index) < CLASS_COUNT;
    assign slot_ok = 32'(map_slot) < MAP_DEPTH;
    assign rd_ok   = cls_ok && (32'(ram_select) < RAM_COUNT)
                     && (32'(ram_address) < RAM_SIZE);

    // Split a map slot into RAM row and address-bit lane.
    always_comb
    begin
        slot_row  = '0;
        slot_lane = '0;
        for (int m = 0; m < RAM_COUNT; m++)
        begin
            if ((32'(map_slot) >= m * ADDR_BITS) && (32'(map_slot) < (m + 1) * ADDR_BITS))
            begin
                slot_row  = ROW_W'(m);
                slot_lane = LANE_W'(32'(map_slot) - m * ADDR_BITS);
            end
        end
    end

    // RAM address from the mapped pattern bits; the first lane is the MSB.
    always_comb
    begin
        ram_addr = '0;
        for (int n = 0; n < ADDR_BITS; n++)
        begin
            ram_addr[ADDR_BITS-1-n] = (32'(map_rd_data[n]) < TOTAL_BITS)
                                      && pattern_reg[map_rd_data[n]];
        end
    end

    assign train_idx = cnt_index(cls_reg, p1_ram_reg, ram_addr);
    assign read_idx  = cnt_index(cls_reg, ROW_W'(rsel_reg), ADDR_BITS'(raddr_reg));

    // Saturating increment of the counter read back.
    assign cnt_inc  = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + COUNT_WIDTH'(1);
    assign cnt_wide = 32'(cnt_rd_data);

    assign train_done = (ram_cnt_reg == limit_reg) && !p1_valid_reg && !p2_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == CIDX_W'(CNT_DEPTH - 1))
                begin
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        CMD_LOAD:  state_next = ST_DONE;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_TRAIN: state_next = ST_TRAIN;
                        CMD_READ:  state_next = ST_READ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_TRAIN:
            begin
                if (train_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:  state_next = ST_RDATA;
            ST_RDATA: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory strobes, pipeline and result.
    always_comb
    begin
        map_ctl        = '0;
        map_wr_row     = slot_row;
        map_wr_lane    = slot_lane;
        map_wr_data    = source_bit;
        map_rd_row     = ram_cnt_reg[ROW_W-1:0];
        cnt_ctl        = '0;
        cnt_wr_idx     = p2_idx_reg;
        cnt_wr_data    = cnt_inc;
        cnt_rd_idx     = train_idx;
        res_count_next = res_count_reg;

        // Map load happens on the accepting edge.
        map_ctl.wr_en = accept && (in_cmd == CMD_LOAD) && slot_ok;

        // Stage 0: read the map row of the next RAM.
        map_ctl.rd_en = (state_reg == ST_TRAIN) && (ram_cnt_reg != limit_reg);
        p1_valid_next = map_ctl.rd_en;
        p2_valid_next = p1_valid_reg;
        ram_cnt_next  = accept ? '0 : ram_cnt_reg + RCNT_W'(map_ctl.rd_en);

        // Stage 1: read the addressed counter; a read command uses the same port.
        if (p1_valid_reg)
        begin
            cnt_ctl.rd_en = 1'b1;
        end
        else if (state_reg == ST_READ)
        begin
            cnt_ctl.rd_en = rd_ok_reg;
            cnt_rd_idx    = read_idx;
        end

        // Stage 2: write back, or sweep zeros while clearing.
        if (state_reg == ST_CLEAR)
        begin
            cnt_ctl.wr_en = 1'b1;
            cnt_wr_idx    = clr_idx_reg;
            cnt_wr_data   = '0;
        end
        else if (p2_valid_reg)
        begin
            cnt_ctl.wr_en = 1'b1;
        end

        clr_idx_next = (state_reg == ST_CLEAR) ? clr_idx_reg + CIDX_W'(1) : '0;
        clr_cmd_next = accept ? 1'b1 : clr_cmd_reg;

        // Training limit, zero for a class out of range, else rams_in_use capped at RAM_COUNT.
        if (!cls_ok)
        begin
            limit_next = '0;
        end
        else if (32'(rams_in_use) > RAM_COUNT)
        begin
            limit_next = RCNT_W'(RAM_COUNT);
        end
        else
        begin
            limit_next = RCNT_W'(rams_in_use);
        end

        if (accept)
        begin
            res_count_next = '0;
        end
        else if (state_reg == ST_RDATA)
        begin
            res_count_next = rd_ok_reg ? cnt_wide[COUNT_OUT_W-1:0] : '0;
        end

        res.push       = (state_reg == ST_DONE) && out_free;
        res.read_valid = (cmd_reg == CMD_READ);
        res.count      = res_count_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cmd_reg  <= 1'b0;
            clr_idx_reg  <= '0;
            ram_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cmd_reg  <= clr_cmd_next;
            clr_idx_reg  <= clr_idx_next;
            ram_cnt_reg  <= ram_cnt_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= in_cmd;
            pattern_reg <= pattern;
            cls_reg     <= class_index;
            rsel_reg    <= ram_select;
            raddr_reg   <= ram_address;
            rd_ok_reg   <= rd_ok;
            limit_reg   <= limit_next;
        end
        p1_ram_reg    <= ram_cnt_reg[ROW_W-1:0];
        p2_idx_reg    <= train_idx;
        res_count_reg <= res_count_next;
    end

endmodule

FILE: src/weightless_net_trainer.sv
// Channel  Dir  Handshake             Payload
// cfg      in   cfg_wr_en             cfg_wr_data (rams_in_use)
// in       in   in_valid / in_stall   command, pattern, class_index, map_slot,
//                                     source_bit, ram_select, ram_address
// out      out  out_valid / out_stall count, read_valid
//
// A train does one counter read-modify-write per RAM, for min(rams_in_use, RAM_COUNT)
// RAMs, through the single counter memory.
// A clear sweeps the counter memory one entry per cycle (all CNT_DEPTH entries,
// 2048 by default); the same sweep runs after reset with in_stall high.
// One result waits in the output register while the next transaction is
// accepted; that transaction completes once the register has drained.
module weightless_net_trainer
    import wnt_pkg::*;
#(
    parameter int TOTAL_BITS  = TOTAL_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int RAM_COUNT   = RAM_COUNT_DEF,
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CMD_W-1:0]       command,
    input  logic [PATTERN_W-1:0]   pattern,
    input  logic [CLASS_W-1:0]     class_index,
    input  logic [SLOT_W-1:0]      map_slot,
    input  logic [SRC_W-1:0]       source_bit,
    input  logic [RSEL_W-1:0]      ram_select,
    input  logic [RADDR_W-1:0]     ram_address,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COUNT_OUT_W-1:0] count,
    output logic                   read_valid
);

    localparam int CNT_DEPTH = CLASS_COUNT * RAM_COUNT * (1 << ADDR_BITS);
    localparam int CIDX_W    = $clog2(CNT_DEPTH);
    localparam int ROW_W     = (RAM_COUNT > 1) ? $clog2(RAM_COUNT) : 1;
    localparam int LANE_W    = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;

    logic [CFG_W-1:0]                rams_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [COUNT_OUT_W-1:0]          count_reg;
    logic                            read_valid_reg;
    logic                            out_free;
    res_t                            res;
    mem_ctl_t                        map_ctl;
    logic [ROW_W-1:0]                map_wr_row;
    logic [LANE_W-1:0]               map_wr_lane;
    logic [SRC_W-1:0]                map_wr_data;
    logic [ROW_W-1:0]                map_rd_row;
    logic [ADDR_BITS-1:0][SRC_W-1:0] map_rd_data;
    mem_ctl_t                        cnt_ctl;
    logic [CIDX_W-1:0]               cnt_wr_idx;
    logic [COUNT_WIDTH-1:0]          cnt_wr_data;
    logic [CIDX_W-1:0]               cnt_rd_idx;
    logic [COUNT_WIDTH-1:0]          cnt_rd_data;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rams_reg <= RAMS_RESET;
        end
        else if (cfg_wr_en)
        begin
            rams_reg <= cfg_wr_data;
        end
    end

    // Bit map storage.
    wnt_map_ram #(
        .RAM_COUNT (RAM_COUNT),
        .ADDR_BITS (ADDR_BITS)
    ) u_map_ram (
        .clk     (clk),
        .ctl     (map_ctl),
        .wr_row  (map_wr_row),
        .wr_lane (map_wr_lane),
        .wr_data (map_wr_data),
        .rd_row  (map_rd_row),
        .rd_data (map_rd_data)
    );

    // Counter storage.
    wnt_cnt_ram #(
        .DEPTH (CNT_DEPTH),
        .WIDTH (COUNT_WIDTH)
    ) u_cnt_ram (
        .clk     (clk),
        .ctl     (cnt_ctl),
        .wr_idx  (cnt_wr_idx),
        .wr_data (cnt_wr_data),
        .rd_idx  (cnt_rd_idx),
        .rd_data (cnt_rd_data)
    );

    // Command sequencer.
    wnt_seq #(
        .TOTAL_BITS  (TOTAL_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .RAM_COUNT   (RAM_COUNT),
        .CLASS_COUNT (CLASS_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .pattern     (pattern),
        .class_index (class_index),
        .map_slot    (map_slot),
        .source_bit  (source_bit),
        .ram_select  (ram_select),
        .ram_address (ram_address),
        .rams_in_use (rams_reg),
        .out_free    (out_free),
        .res         (res),
        .map_ctl     (map_ctl),
        .map_wr_row  (map_wr_row),
        .map_wr_lane (map_wr_lane),
        .map_wr_data (map_wr_data),
        .map_rd_row  (map_rd_row),
        .map_rd_data (map_rd_data),
        .cnt_ctl     (cnt_ctl),
        .cnt_wr_idx  (cnt_wr_idx),
        .cnt_wr_data (cnt_wr_data),
        .cnt_rd_idx  (cnt_rd_idx),
        .cnt_rd_data (cnt_rd_data)
    );

    // Output register: free when empty or drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            count_reg      <= res.count;
            read_valid_reg <= res.read_valid;
        end
    end

    assign out_valid  = out_valid_reg;
    assign count      = count_reg;
    assign read_valid = read_valid_reg;

endmodule

FILE: src/wnt_port_checker.sv
`include "weightless_net_trainer_assert.svh"

module wnt_port_checker
    import wnt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [COUNT_OUT_W-1:0] count,
    input logic                   read_valid
);

    // A stalled result keeps its payload.
    `WNT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(count) && $stable(read_valid), "result changed while stalled")

    // Only a read carries a nonzero count.
    `WNT_ASSERT_SAME(a_zero_count, clk, rst_n, out_valid && !read_valid, count == '0, "nonzero count without read")

    // The block is busy in the cycle after every accepted transaction.
    `WNT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after a transaction")

    // A new result is issued only from a busy sequencer.
    `WNT_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared while idle")

endmodule

bind weightless_net_trainer wnt_port_checker u_port_checker (.*);
